/* rtl/ibanchk_pkg.sv */
// Shared types, constants and helper functions for the account number checker.
// Holds the country code table and the constant-modulus reduction used by all stages.
// No dependencies.
package ibanchk_pkg;

  localparam int CHAR_W       = 8;
  localparam int COUNT_W      = 6;
  localparam int REM_W        = 7;
  localparam int DIGITS_W     = 4;
  localparam int STATUS_W     = 3;
  localparam int WIDE_W       = 14;
  localparam int MODULUS      = 97;
  localparam int MIN_LENGTH   = 4;
  localparam int FRONT_LEN    = 4;
  localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
  localparam int MAX_LENGTH_DEF = 34;
  localparam int NUM_COUNTRIES  = 144;

  // Reciprocal of the modulus scaled by 2^16, rounded down
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (1 << RECIP_SHIFT) / MODULUS;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID    = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LONG     = 3'd2,
    ST_COUNTRY  = 3'd3,
    ST_BAD_CHAR = 3'd4,
    ST_CHECKSUM = 3'd5
  } status_t;

  // Hand-off from the accumulate stage to the finish stage
  typedef struct packed {
    status_t               status;     // ST_VALID means "checksum still to be judged"
    logic [REM_W-1:0]      run_rem;    // remainder of characters after the front four
    logic [REM_W-1:0]      front_rem;  // remainder of the front four on their own
    logic [DIGITS_W-1:0]   digits;     // decimal digits the front four expand to
  } finish_t;

  // Supported two-letter country codes, uppercase; the last two slots are empty
  // and so match a pair of NUL codes
  localparam logic [2*CHAR_W-1:0] COUNTRY_ROM [NUM_COUNTRIES] = '{
    "AE","AF","AL","AM","AN","AR","AT","AU","AZ","BA","BD","BE","BG","BH",
    "BN","BO","BR","BT","BY","BZ","CA","CG","CH","CI","CL","CM","CN","CO",
    "CR","CS","CZ","DE","DK","DO","DZ","EC","EE","EG","ER","ES","ET","FI",
    "FO","FR","GB","GD","GE","GL","GR","GT","HK","HN","HR","HT","HU","ID",
    "IE","IL","IN","IQ","IR","IS","IT","JM","JO","JP","KE","KG","KH","KR",
    "KW","KZ","LA","LB","LI","LK","LT","LU","LV","LY","MA","MC","MD","ME",
    "MK","ML","MM","MN","MO","MT","MV","MX","MY","NG","NI","NL","NO","NP",
    "NZ","OM","PA","PE","PH","PK","PL","PR","PT","PY","QA","RE","RO","RS",
    "RU","RW","SA","SE","SG","SI","SK","SN","SO","SR","SV","SY","TH","TJ",
    "TM","TN","TR","TT","TW","TZ","UA","US","UY","VA","VE","VN","YE","ZA",
    "ZW","ZW",16'h0000,16'h0000
  };

  // x mod 97 for x below 97*128: reciprocal estimate is low by at most one
  function automatic logic [REM_W-1:0] mod97(input logic [WIDE_W-1:0] x);
    logic [23:0]       prod;
    logic [REM_W-1:0]  q;
    logic [WIDE_W-1:0] r;
    prod = {10'd0, x} * 24'(RECIP);
    q    = prod[RECIP_SHIFT+REM_W-1:RECIP_SHIFT];
    r    = x - ({7'd0, q} * WIDE_W'(MODULUS));
    if (r >= WIDE_W'(MODULUS)) begin
      r = r - WIDE_W'(MODULUS);
    end
    return r[REM_W-1:0];
  endfunction

  // 10^k mod 97 for the digit count of the front four characters
  function automatic logic [REM_W-1:0] pow10_mod97(input logic [DIGITS_W-1:0] k);
    logic [REM_W-1:0] p;
    case (k)
      4'd0:    p = 7'd1;
      4'd1:    p = 7'd10;
      4'd2:    p = 7'd3;
      4'd3:    p = 7'd30;
      4'd4:    p = 7'd9;
      4'd5:    p = 7'd90;
      4'd6:    p = 7'd27;
      4'd7:    p = 7'd76;
      4'd8:    p = 7'd81;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

  // Parallel compare against every table entry
  function automatic logic country_known(input logic [CHAR_W-1:0] c0,
                                         input logic [CHAR_W-1:0] c1);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_COUNTRIES; i++) begin
      if (COUNTRY_ROM[i] == {c0, c1}) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

/* rtl/ibanchk_in_if.sv */
// Character channel: valid/ready handshake carrying one ASCII character per transaction.
// Depends on ibanchk_pkg for field widths.
interface ibanchk_in_if;
  logic                             valid;
  logic                             ready;
  logic [ibanchk_pkg::CHAR_W-1:0]   char_code;
  logic                             last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* rtl/ibanchk_out_if.sv */
// Result channel: valid/ready handshake carrying one status and remainder per transaction.
// Depends on ibanchk_pkg for field widths.
interface ibanchk_out_if;
  logic                             valid;
  logic                             ready;
  logic [ibanchk_pkg::STATUS_W-1:0] status;
  logic [ibanchk_pkg::REM_W-1:0]    final_remainder;

  modport source (output valid, output status, output final_remainder, input ready);
  modport sink   (input valid, input status, input final_remainder, output ready);
endinterface

/* rtl/iban_checksum_validator.sv */
// Account number checker, one ASCII character per transaction, mod-97 checksum.
// Throughput: one character per cycle, except that a last character waits while the finish record register is full.
// The result for a number passes from the input register through the finish record register to the output register.
// The output register holds a waiting result while further characters are taken.
// Reset (rst, synchronous) empties both pipeline stages and clears the per-number state.
// Depends on ibanchk_pkg, ibanchk_in_if, ibanchk_out_if, ibanchk_accum, ibanchk_finish.
module iban_checksum_validator #(
  parameter int MAX_LENGTH = ibanchk_pkg::MAX_LENGTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ibanchk_in_if.sink    chars,
  ibanchk_out_if.source results
);
  import ibanchk_pkg::*;

  logic    fin_valid;
  logic    fin_ready;
  finish_t fin;

  // Per-character accumulation
  ibanchk_accum #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  // Checksum judgment and output register
  ibanchk_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin),
    .results   (results)
  );

endmodule

/* rtl/ibanchk_accum.sv */
// Input register and per-character state update: running remainders, length count,
// country check and bad character flag. Emits a finish record on the last character.
// Depends on ibanchk_pkg and ibanchk_in_if.
module ibanchk_accum #(
  parameter int MAX_LENGTH = ibanchk_pkg::MAX_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  ibanchk_in_if.sink           chars,
  output logic                 fin_valid,
  input  logic                 fin_ready,
  output ibanchk_pkg::finish_t fin
);
  import ibanchk_pkg::*;

  // Input register
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;
  logic              s1_adv;

  // Per-number state
  logic [REM_W-1:0]    run_rem;
  logic [REM_W-1:0]    front_rem;
  logic [DIGITS_W-1:0] front_digits;
  logic [COUNT_W-1:0]  count;
  logic                bad_seen;
  logic [CHAR_W-1:0]   front0;
  logic                country_ok;

  // Update logic
  logic                is_digit;
  logic                is_letter;
  logic                in_front;
  logic [REM_W-1:0]    acc;
  logic [REM_W-1:0]    folded;
  logic [REM_W-1:0]    let_val;
  logic [COUNT_W-1:0]  count_next;
  logic [DIGITS_W-1:0] digits_next;
  logic                bad_next;
  finish_t             fin_next;

  // Last characters wait for the finish register; others retire at once
  assign s1_adv      = s1_valid && (!s1_last || !fin_valid || fin_ready);
  assign chars.ready = !s1_valid || s1_adv;

  // Character classification and fold into the selected remainder
  always_comb begin
    is_digit  = s1_char inside {[8'h30:8'h39]};
    is_letter = s1_char inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    in_front  = count < COUNT_W'(FRONT_LEN);
    acc       = in_front ? front_rem : run_rem;
    let_val   = s1_char[REM_W-1:0] - 7'd55;
    if (is_digit) begin
      folded = mod97(({7'd0, acc} * 14'd10) + {10'd0, s1_char[3:0]});
    end else if (is_letter) begin
      // 100 mod 97 is 3
      folded = mod97(({7'd0, acc} * 14'd3) + {7'd0, let_val});
    end else begin
      folded = acc;
    end
    count_next  = (count == COUNT_W'(COUNT_MAX)) ? count : count + 1'b1;
    digits_next = front_digits;
    if (in_front && is_digit) begin
      digits_next = front_digits + 4'd1;
    end else if (in_front && is_letter) begin
      digits_next = front_digits + 4'd2;
    end
    bad_next = bad_seen || !(is_digit || is_letter);
  end

  // Status in priority order; ST_VALID leaves the checksum to the finish stage
  always_comb begin
    if (count_next < COUNT_W'(MIN_LENGTH)) begin
      fin_next.status = ST_SHORT;
    end else if (count_next > COUNT_W'(MAX_LENGTH)) begin
      fin_next.status = ST_LONG;
    end else if (!country_ok) begin
      fin_next.status = ST_COUNTRY;
    end else if (bad_next) begin
      fin_next.status = ST_BAD_CHAR;
    end else begin
      fin_next.status = ST_VALID;
    end
    fin_next.run_rem   = in_front ? run_rem : folded;
    fin_next.front_rem = in_front ? folded : front_rem;
    fin_next.digits    = digits_next;
  end

  // Control state and remainders
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      fin_valid    <= 1'b0;
      run_rem      <= '0;
      front_rem    <= '0;
      front_digits <= '0;
      count        <= '0;
      bad_seen     <= 1'b0;
    end else begin
      if (chars.valid && chars.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1_last) begin
        fin_valid <= 1'b1;
      end else if (fin_ready) begin
        fin_valid <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_last) begin
          run_rem      <= '0;
          front_rem    <= '0;
          front_digits <= '0;
          count        <= '0;
          bad_seen     <= 1'b0;
        end else begin
          run_rem      <= fin_next.run_rem;
          front_rem    <= fin_next.front_rem;
          front_digits <= digits_next;
          count        <= count_next;
          bad_seen     <= bad_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char <= chars.char_code;
      s1_last <= chars.last_char;
    end
    if (s1_adv && count == COUNT_W'(0)) begin
      front0 <= s1_char;
    end
    if (s1_adv && count == COUNT_W'(1)) begin
      country_ok <= country_known(front0, s1_char);
    end
    if (s1_adv && s1_last) begin
      fin <= fin_next;
    end
  end

`ifndef SYNTHESIS
  // A finished number leaves the per-number state cleared
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> count == '0 && !bad_seen && run_rem == '0)
    else $error("state not cleared after last character");

  // Front four characters never expand to more than eight digits
  a_digits_bound: assert property (@(posedge clk) disable iff (rst)
    front_digits <= 4'd8)
    else $error("front digit count out of range");

  // A record sent for checksum judgment has a full, clean front section
  a_fin_digits: assert property (@(posedge clk) disable iff (rst)
    fin_valid && fin.status == ST_VALID |-> fin.digits >= 4'd4)
    else $error("checksum record with short front section");
`endif

endmodule

/* rtl/ibanchk_finish.sv */
// Finish stage: folds the front four characters behind the running remainder,
// judges the checksum and holds the result in the output register.
// Depends on ibanchk_pkg and ibanchk_out_if.
module ibanchk_finish (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fin_valid,
  output logic                 fin_ready,
  input  ibanchk_pkg::finish_t fin,
  ibanchk_out_if.source        results
);
  import ibanchk_pkg::*;

  logic [WIDE_W-1:0] shifted;
  logic [REM_W-1:0]  rem;
  status_t           status_next;
  logic [REM_W-1:0]  rem_next;

  assign fin_ready = !results.valid || results.ready;

  // Rotated number: running part shifted left by the front digit count, plus the front
  always_comb begin
    shifted = ({7'd0, fin.run_rem} * {7'd0, pow10_mod97(fin.digits)}) + {7'd0, fin.front_rem};
    rem     = mod97(shifted);
    if (fin.status == ST_VALID) begin
      status_next = (rem == 7'd1) ? ST_VALID : ST_CHECKSUM;
      rem_next    = rem;
    end else begin
      status_next = fin.status;
      rem_next    = '0;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fin_ready) begin
      results.valid <= fin_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      results.status          <= status_next;
      results.final_remainder <= rem_next;
    end
  end

`ifndef SYNTHESIS
  // A valid status always carries remainder one
  a_valid_rem: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == ST_VALID |-> results.final_remainder == 7'd1)
    else $error("valid status without remainder one");

  // Early-out statuses report a zero remainder
  a_zero_rem: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status != ST_VALID && results.status != ST_CHECKSUM
    |-> results.final_remainder == '0)
    else $error("nonzero remainder with early-out status");
`endif

endmodule
